// ===== rtl/sfd_pkg.sv =====
//------------------------------------------------------------------------------
// sfd_pkg
// Shared types, codes and the CRC-16 byte update for the sync frame deframer.
//------------------------------------------------------------------------------
`default_nettype none
package sfd_pkg;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	localparam int HDR_BYTES = 7;
	localparam int PAY_BYTES = 12;
	localparam int PAY_IDX_W = 4;
	localparam int TOTAL_W   = 7;
	localparam logic [TOTAL_W-1:0] TRAILER_PLUS_HDR = 7'd9;

	localparam int QDEPTH = 2;

	// status codes
	localparam logic [2:0] ST_VISION = 3'd0;
	localparam logic [2:0] ST_IMU    = 3'd1;
	localparam logic [2:0] ST_CRC    = 3'd2;
	localparam logic [2:0] ST_LEN    = 3'd3;
	localparam logic [2:0] ST_FMT    = 3'd4;

	// register indexes
	localparam logic [2:0] REG_SYNC_FIRST  = 3'd0;
	localparam logic [2:0] REG_SYNC_SECOND = 3'd1;
	localparam logic [2:0] REG_VERSION     = 3'd2;
	localparam logic [2:0] REG_PAY_LIMIT   = 3'd3;
	localparam logic [2:0] REG_VIS_KIND    = 3'd4;
	localparam logic [2:0] REG_IMU_KIND    = 3'd5;
	localparam logic [2:0] REG_VIS_LEN     = 3'd6;
	localparam logic [2:0] REG_IMU_LEN     = 3'd7;

	typedef struct packed {
		logic [7:0] sync_first;
		logic [7:0] sync_second;
		logic [7:0] version_expected;
		logic [5:0] payload_limit;
		logic [7:0] vision_kind;
		logic [7:0] imu_kind;
		logic [5:0] vision_length;
		logic [5:0] imu_length;
	} cfg_t;

	// frame event handed from the parser to the result side
	typedef struct packed {
		logic        len_err;
		logic        crc_ok;
		logic        is_vis;
		logic        is_imu;
		logic [7:0]  flags;
		logic [7:0]  seq;
		logic [31:0] wx;
		logic [31:0] wy;
		logic [31:0] wz;
	} evt_t;

	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15])
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			else
				c = {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/sync_frame_crc16_deframer.sv =====
//------------------------------------------------------------------------------
// sync_frame_crc16_deframer
// Sync-framed serial deframer with CRC-16/CCITT-FALSE check, top level.
//------------------------------------------------------------------------------
// Takes one received byte per beat, one beat per clock while in_stall is low.
// The parser hunts for the two sync bytes, checks version and payload limit
// on the header, runs the CRC (poly 0x1021, init 0xFFFF) over version..payload
// one byte per cycle and, at the last CRC byte, queues one frame event. Header
// rejects and store overflows also queue an event (status 3). The result
// side pops events into an output register, so a frame's result passes
// through the event queue and then that register. A two-entry event queue sits
// between the two sides; in_stall rises only when that queue is full, i.e.
// when results are held off at the output. Counters wrap at 2^32 and show
// the value after the event of the current beat. Config writes (cfg_we,
// cfg_index, cfg_data) take effect at the next edge and should only be done
// while idle.
//------------------------------------------------------------------------------
`default_nettype none
module sync_frame_crc16_deframer #(
	parameter int FRAME_BYTES = 64
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire  [2:0]  cfg_index,
	input  wire  [7:0]  cfg_data,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [7:0]  rx_byte,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [2:0]  status,
	output logic [7:0]  frame_flags,
	output logic [7:0]  frame_seq,
	output logic [31:0] word_x,
	output logic [31:0] word_y,
	output logic [31:0] word_z,
	output logic [7:0]  echo_seq,
	output logic [31:0] crc_errors,
	output logic [31:0] length_errors,
	output logic [31:0] format_errors,
	output logic [31:0] vision_frames,
	output logic [31:0] imu_frames
);
	import sfd_pkg::*;

	cfg_t cfg_q;
	evt_t ev_push, ev_head;
	logic take, push, pop, q_full, q_avail;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_first       <= 8'hAA;
			cfg_q.sync_second      <= 8'h55;
			cfg_q.version_expected <= 8'd1;
			cfg_q.payload_limit    <= 6'd16;
			cfg_q.vision_kind      <= 8'd1;
			cfg_q.imu_kind         <= 8'd2;
			cfg_q.vision_length    <= 6'd9;
			cfg_q.imu_length       <= 6'd12;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SYNC_FIRST:  cfg_q.sync_first       <= cfg_data;
				REG_SYNC_SECOND: cfg_q.sync_second      <= cfg_data;
				REG_VERSION:     cfg_q.version_expected <= cfg_data;
				REG_PAY_LIMIT:   cfg_q.payload_limit    <= cfg_data[5:0];
				REG_VIS_KIND:    cfg_q.vision_kind      <= cfg_data;
				REG_IMU_KIND:    cfg_q.imu_kind         <= cfg_data;
				REG_VIS_LEN:     cfg_q.vision_length    <= cfg_data[5:0];
				REG_IMU_LEN:     cfg_q.imu_length       <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// a byte beat is taken whenever the event queue has room
	assign in_stall = q_full;
	assign take     = in_valid && !q_full;

	sfd_front #(.FRAME_BYTES(FRAME_BYTES)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.rx_byte (rx_byte),
		.cfg     (cfg_q),
		.push    (push),
		.evt     (ev_push)
	);

	sfd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wdata    (ev_push),
		.pop      (pop),
		.rdata    (ev_head),
		.full     (q_full),
		.nonempty (q_avail)
	);

	sfd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.ev_avail      (q_avail),
		.ev            (ev_head),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.frame_flags   (frame_flags),
		.frame_seq     (frame_seq),
		.word_x        (word_x),
		.word_y        (word_y),
		.word_z        (word_z),
		.echo_seq      (echo_seq),
		.crc_errors    (crc_errors),
		.length_errors (length_errors),
		.format_errors (format_errors),
		.vision_frames (vision_frames),
		.imu_frames    (imu_frames)
	);

	a_stall_only_when_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with output register empty");

endmodule
`default_nettype wire

// ===== rtl/sfd_front.sv =====
//------------------------------------------------------------------------------
// sfd_front
// Byte parser: sync hunt, header capture and checks, CRC, frame end detect.
//------------------------------------------------------------------------------
`default_nettype none
module sfd_front #(
	parameter int FRAME_BYTES = 64
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              take,
	input  wire [7:0]        rx_byte,
	input  sfd_pkg::cfg_t    cfg,
	output logic             push,
	output sfd_pkg::evt_t    evt
);
	import sfd_pkg::*;

	localparam int POS_W = $clog2(FRAME_BYTES + 1);
	localparam logic [1:0] PH_FIRST  = 2'd0;
	localparam logic [1:0] PH_SECOND = 2'd1;
	localparam logic [1:0] PH_BODY   = 2'd2;

	logic [1:0]         phase_q, phase_nx;
	logic [POS_W-1:0]   pos_q, pos_nx;
	logic [TOTAL_W-1:0] total_q, total_nx;
	logic [15:0]        crc_q, crc_nx;
	logic [7:0]         ver_q, kind_q, flags_q, seq_q, len_q, prev_q;
	logic [7:0]         pay_q [PAY_BYTES];

	logic [7:0]         pos_w, pos1_w;
	logic               hdr_bad, finish, crc_take;
	logic [POS_W-1:0]   pay_off;

	assign pos_w   = 8'(pos_q);
	assign pos1_w  = pos_w + 8'd1;
	assign pay_off = pos_q - POS_W'(HDR_BYTES);
	assign hdr_bad = (ver_q != cfg.version_expected) || (rx_byte > {2'b00, cfg.payload_limit});

	always_comb begin
		phase_nx = phase_q;
		pos_nx   = pos_q;
		total_nx = total_q;
		crc_nx   = crc_q;
		push     = 1'b0;
		finish   = 1'b0;
		crc_take = 1'b0;
		evt      = '0;
		if (take) begin
			case (phase_q)
				PH_SECOND: begin
					if (rx_byte == cfg.sync_second) begin
						phase_nx = PH_BODY;
						pos_nx   = POS_W'(2);
						total_nx = '0;
						crc_nx   = CRC_INIT;
					end else if (rx_byte != cfg.sync_first) begin
						phase_nx = PH_FIRST;
						pos_nx   = '0;
						total_nx = '0;
						crc_nx   = CRC_INIT;
					end
				end
				PH_BODY: begin
					if (pos_w >= 8'(FRAME_BYTES)) begin
						push        = 1'b1;
						evt.len_err = 1'b1;
						phase_nx    = PH_FIRST;
						pos_nx      = '0;
						total_nx    = '0;
						crc_nx      = CRC_INIT;
					end else begin
						pos_nx   = pos_q + POS_W'(1);
						crc_take = (pos_w < 8'(HDR_BYTES)) || (pos_w + 8'd2 < {1'b0, total_q});
						if (crc_take)
							crc_nx = crc_feed(crc_q, rx_byte);
						if (pos_w == 8'(HDR_BYTES - 1)) begin
							if (hdr_bad) begin
								push        = 1'b1;
								evt.len_err = 1'b1;
								phase_nx    = PH_FIRST;
								pos_nx      = '0;
								crc_nx      = CRC_INIT;
							end else begin
								total_nx = TOTAL_W'(rx_byte[5:0]) + TRAILER_PLUS_HDR;
							end
						end
						finish = (phase_nx == PH_BODY) && (total_nx != '0)
							&& (pos1_w == {1'b0, total_nx});
						if (finish) begin
							push       = 1'b1;
							evt.crc_ok = ({prev_q, rx_byte} == crc_nx);
							evt.is_vis = (kind_q == cfg.vision_kind)
								&& (len_q == {2'b00, cfg.vision_length});
							evt.is_imu = (kind_q == cfg.imu_kind)
								&& (len_q == {2'b00, cfg.imu_length});
							evt.flags  = flags_q;
							evt.seq    = seq_q;
							evt.wx     = {pay_q[0], pay_q[1], pay_q[2], pay_q[3]};
							evt.wy     = {pay_q[4], pay_q[5], pay_q[6], pay_q[7]};
							evt.wz     = {pay_q[8], pay_q[9], pay_q[10], pay_q[11]};
							phase_nx   = PH_FIRST;
							pos_nx     = '0;
							total_nx   = '0;
							crc_nx     = CRC_INIT;
						end
					end
				end
				default: begin
					if (rx_byte == cfg.sync_first)
						phase_nx = PH_SECOND;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			pos_q   <= '0;
			total_q <= '0;
			crc_q   <= CRC_INIT;
		end else begin
			phase_q <= phase_nx;
			pos_q   <= pos_nx;
			total_q <= total_nx;
			crc_q   <= crc_nx;
		end
	end

	// header and payload bytes; the last pair of a frame is the sent CRC
	always_ff @(posedge clk) begin
		if (take && phase_q == PH_BODY && pos_w < 8'(FRAME_BYTES)) begin
			prev_q <= rx_byte;
			case (pos_w)
				8'd2:    ver_q   <= rx_byte;
				8'd3:    kind_q  <= rx_byte;
				8'd4:    flags_q <= rx_byte;
				8'd5:    seq_q   <= rx_byte;
				8'd6:    len_q   <= rx_byte;
				default: ;
			endcase
			if (pos_w >= 8'(HDR_BYTES) && pos_w < 8'(HDR_BYTES + PAY_BYTES))
				pay_q[pay_off[PAY_IDX_W-1:0]] <= rx_byte;
		end
	end

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		8'(pos_q) <= 8'(FRAME_BYTES))
		else $error("byte position past store size");

endmodule
`default_nettype wire

// ===== rtl/sfd_queue.sv =====
//------------------------------------------------------------------------------
// sfd_queue
// Short event queue between the parser and the result side.
//------------------------------------------------------------------------------
`default_nettype none
module sfd_queue (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            push,
	input  sfd_pkg::evt_t  wdata,
	input  wire            pop,
	output sfd_pkg::evt_t  rdata,
	output logic           full,
	output logic           nonempty
);
	import sfd_pkg::*;

	localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CNT_W = $clog2(QDEPTH + 1);

	evt_t             mem_q [QDEPTH];
	logic [PTR_W-1:0] wp_q, rp_q;
	logic [CNT_W-1:0] cnt_q;

	assign full     = (cnt_q == CNT_W'(QDEPTH));
	assign nonempty = (cnt_q != '0);
	assign rdata    = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= (wp_q == PTR_W'(QDEPTH - 1)) ? '0 : wp_q + PTR_W'(1);
			if (pop)
				rp_q <= (rp_q == PTR_W'(QDEPTH - 1)) ? '0 : rp_q + PTR_W'(1);
			cnt_q <= cnt_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("event pushed into full queue");

endmodule
`default_nettype wire

// ===== rtl/sfd_back.sv =====
//------------------------------------------------------------------------------
// sfd_back
// Result side: final verdict, tallies and the output register.
//------------------------------------------------------------------------------
`default_nettype none
module sfd_back (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            ev_avail,
	input  sfd_pkg::evt_t  ev,
	output logic           pop,
	output logic           out_valid,
	input  wire            out_stall,
	output logic [2:0]     status,
	output logic [7:0]     frame_flags,
	output logic [7:0]     frame_seq,
	output logic [31:0]    word_x,
	output logic [31:0]    word_y,
	output logic [31:0]    word_z,
	output logic [7:0]     echo_seq,
	output logic [31:0]    crc_errors,
	output logic [31:0]    length_errors,
	output logic [31:0]    format_errors,
	output logic [31:0]    vision_frames,
	output logic [31:0]    imu_frames
);
	import sfd_pkg::*;

	logic        valid_q;
	logic [2:0]  status_q, st;
	logic [7:0]  flags_q, seq_q, echo_q;
	logic [31:0] wx_q, wy_q, wz_q;
	logic [31:0] crc_cnt_q, len_cnt_q, fmt_cnt_q, vis_cnt_q, imu_cnt_q;
	logic        nf_x, nf_y, nf_z;

	assign pop  = ev_avail && (!valid_q || !out_stall);
	assign nf_x = &ev.wx[30:23];
	assign nf_y = &ev.wy[30:23];
	assign nf_z = &ev.wz[30:23];

	always_comb begin
		if (ev.len_err)
			st = ST_LEN;
		else if (!ev.crc_ok)
			st = ST_CRC;
		else if (ev.is_vis)
			st = (nf_x || nf_y) ? ST_FMT : ST_VISION;
		else if (ev.is_imu)
			st = (nf_x || nf_y || nf_z) ? ST_FMT : ST_IMU;
		else
			st = ST_LEN;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			crc_cnt_q <= '0;
			len_cnt_q <= '0;
			fmt_cnt_q <= '0;
			vis_cnt_q <= '0;
			imu_cnt_q <= '0;
		end else begin
			if (pop)
				valid_q <= 1'b1;
			else if (!out_stall)
				valid_q <= 1'b0;
			if (pop) begin
				case (st)
					ST_VISION: vis_cnt_q <= vis_cnt_q + 32'd1;
					ST_IMU:    imu_cnt_q <= imu_cnt_q + 32'd1;
					ST_CRC:    crc_cnt_q <= crc_cnt_q + 32'd1;
					ST_FMT:    fmt_cnt_q <= fmt_cnt_q + 32'd1;
					default:   len_cnt_q <= len_cnt_q + 32'd1;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			status_q <= st;
			flags_q  <= '0;
			seq_q    <= '0;
			wx_q     <= '0;
			wy_q     <= '0;
			wz_q     <= '0;
			echo_q   <= '0;
			if (st == ST_VISION || st == ST_IMU) begin
				flags_q <= ev.flags;
				seq_q   <= ev.seq;
				wx_q    <= ev.wx;
				wy_q    <= ev.wy;
			end
			if (st == ST_VISION)
				echo_q <= ev.wz[31:24];
			if (st == ST_IMU)
				wz_q <= ev.wz;
		end
	end

	assign out_valid     = valid_q;
	assign status        = status_q;
	assign frame_flags   = flags_q;
	assign frame_seq     = seq_q;
	assign word_x        = wx_q;
	assign word_y        = wy_q;
	assign word_z        = wz_q;
	assign echo_seq      = echo_q;
	assign crc_errors    = crc_cnt_q;
	assign length_errors = len_cnt_q;
	assign format_errors = fmt_cnt_q;
	assign vision_frames = vis_cnt_q;
	assign imu_frames    = imu_cnt_q;

	a_pop_shows: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> valid_q)
		else $error("popped event not presented");

endmodule
`default_nettype wire

// ===== tb/tb_sync_frame_crc16_deframer.sv =====
//------------------------------------------------------------------------------
// tb_sync_frame_crc16_deframer
// Self-checking bench for the sync frame deframer: builds framed byte streams
// (good frames, CRC faults, bad headers, non-finite words, cut frames, noise),
// predicts each frame event in a local parser model and checks every result.
//------------------------------------------------------------------------------
`default_nettype none
module tb_sync_frame_crc16_deframer;
	import sfd_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [7:0]  cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  status;
	logic [7:0]  frame_flags;
	logic [7:0]  frame_seq;
	logic [31:0] word_x;
	logic [31:0] word_y;
	logic [31:0] word_z;
	logic [7:0]  echo_seq;
	logic [31:0] crc_errors;
	logic [31:0] length_errors;
	logic [31:0] format_errors;
	logic [31:0] vision_frames;
	logic [31:0] imu_frames;

	sync_frame_crc16_deframer #(.FRAME_BYTES(64)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .frame_flags(frame_flags), .frame_seq(frame_seq),
		.word_x(word_x), .word_y(word_y), .word_z(word_z), .echo_seq(echo_seq),
		.crc_errors(crc_errors), .length_errors(length_errors),
		.format_errors(format_errors), .vision_frames(vision_frames),
		.imu_frames(imu_frames)
	);

	// one frame event as seen on the result port
	typedef struct packed {
		logic [2:0]  st;
		logic [7:0]  flags;
		logic [7:0]  seq;
		logic [31:0] wx;
		logic [31:0] wy;
		logic [31:0] wz;
		logic [7:0]  echo;
		logic [31:0] n_crc;
		logic [31:0] n_len;
		logic [31:0] n_fmt;
		logic [31:0] n_vis;
		logic [31:0] n_imu;
	} frame_event_t;

	typedef enum logic [1:0] {HUNT_FIRST, HUNT_SECOND, IN_BODY} hunt_e;

	localparam int STORE_BYTES  = 64;
	localparam int IDLE_LIMIT   = 3000;  // well above the longest hold and the widest gap
	localparam int DRAIN_CYCLES = 12;    // parser + event queue + output reg
	localparam int LONG_HOLD    = 400;

	// parser model state
	cfg_t        regs;
	hunt_e       phase;
	logic [7:0]  store [STORE_BYTES];
	int          pos;
	int          total;
	logic [15:0] crc_run;
	logic [31:0] t_crc, t_len, t_fmt, t_vis, t_imu;

	frame_event_t pending_events[$];

	int  mismatches;
	bit  failed;
	int  idle_cycles;
	int  gap_max;       // per-beat gap ceiling for both sides, 0 = back to back
	bit  hold_request;  // asks the receiver for one long hold-off
	int  bytes_sent;

	//--------------------------------------------------------------------------
	// clock, watchdog
	//--------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// counts cycles with no beat on either channel and no register write
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("tb_sync_frame_crc16_deframer: FAIL");
			$finish;
		end
	end

	//--------------------------------------------------------------------------
	// parser model
	//--------------------------------------------------------------------------
	function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {b, 8'h00};
		repeat (8) r = r[15] ? ((r << 1) ^ 16'h1021) : (r << 1);
		return r;
	endfunction

	function automatic logic [31:0] word_from(input int i);
		return {store[i], store[i+1], store[i+2], store[i+3]};
	endfunction

	function automatic bit not_finite(input logic [31:0] w);
		return w[30:23] == 8'hFF;
	endfunction

	task automatic rehunt();
		phase   = HUNT_FIRST;
		pos     = 0;
		total   = 0;
		crc_run = 16'hFFFF;
	endtask

	// error events carry only the tallies
	task automatic post_event(input logic [2:0] st, input logic [7:0] fl, input logic [7:0] sq,
	                          input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
	                          input logic [7:0] e);
		frame_event_t ev;
		ev = '{st, fl, sq, x, y, z, e, t_crc, t_len, t_fmt, t_vis, t_imu};
		pending_events.push_back(ev);
	endtask

	task automatic close_frame();
		logic [15:0] got_crc;
		logic [31:0] x, y, z;
		got_crc = {store[total-2], store[total-1]};
		x = word_from(7);
		y = word_from(11);
		if (got_crc != crc_run) begin
			t_crc++;
			post_event(ST_CRC, 0, 0, 0, 0, 0, 0);
		end else if (store[3] == regs.vision_kind && store[6] == 8'(regs.vision_length)) begin
			if (not_finite(x) || not_finite(y)) begin
				t_fmt++;
				post_event(ST_FMT, 0, 0, 0, 0, 0, 0);
			end else begin
				t_vis++;
				post_event(ST_VISION, store[4], store[5], x, y, 0, store[15]);
			end
		end else if (store[3] == regs.imu_kind && store[6] == 8'(regs.imu_length)) begin
			z = word_from(15);
			if (not_finite(x) || not_finite(y) || not_finite(z)) begin
				t_fmt++;
				post_event(ST_FMT, 0, 0, 0, 0, 0, 0);
			end else begin
				t_imu++;
				post_event(ST_IMU, store[4], store[5], x, y, z, 0);
			end
		end else begin
			t_len++;
			post_event(ST_LEN, 0, 0, 0, 0, 0, 0);
		end
	endtask

	// advances the model by one accepted byte
	task automatic parse_byte(input logic [7:0] b);
		int p;
		case (phase)
			HUNT_SECOND: begin
				if (b == regs.sync_second) begin
					store[1] = b;
					pos      = 2;
					total    = 0;
					crc_run  = 16'hFFFF;
					phase    = IN_BODY;
				end else if (b != regs.sync_first) begin
					rehunt();
				end
			end
			IN_BODY: begin
				if (pos >= STORE_BYTES) begin
					// store overflow: byte dropped
					t_len++;
					rehunt();
					post_event(ST_LEN, 0, 0, 0, 0, 0, 0);
				end else begin
					p = pos;
					store[p] = b;
					pos = p + 1;
					if (p < 7 || (total >= 2 && p < total - 2))
						crc_run = crc_byte(crc_run, b);
					if (pos == 7) begin
						if (store[2] != regs.version_expected ||
						    store[6] > 8'(regs.payload_limit)) begin
							t_len++;
							rehunt();
							post_event(ST_LEN, 0, 0, 0, 0, 0, 0);
							return;
						end
						total = 9 + store[6];
					end
					if (total != 0 && pos == total) begin
						close_frame();
						rehunt();
					end
				end
			end
			default: begin
				if (b == regs.sync_first) begin
					store[0] = b;
					phase    = HUNT_SECOND;
				end
			end
		endcase
	endtask

	//--------------------------------------------------------------------------
	// result side: random stall per beat plus the long hold-off on request
	//--------------------------------------------------------------------------
	initial begin
		int wait_left;
		int hold_left;
		frame_event_t want;
		frame_event_t seen;
		string diff;
		wait_left = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				seen = '{status, frame_flags, frame_seq, word_x, word_y, word_z, echo_seq,
				         crc_errors, length_errors, format_errors, vision_frames,
				         imu_frames};
				if (pending_events.size() == 0) begin
					failed = 1'b1;
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result beat: status %0d", status);
				end else begin
					want = pending_events.pop_front();
					diff = "";
					if (seen.st    !== want.st)    diff = {diff, " status"};
					if (seen.flags !== want.flags) diff = {diff, " frame_flags"};
					if (seen.seq   !== want.seq)   diff = {diff, " frame_seq"};
					if (seen.wx    !== want.wx)    diff = {diff, " word_x"};
					if (seen.wy    !== want.wy)    diff = {diff, " word_y"};
					if (seen.wz    !== want.wz)    diff = {diff, " word_z"};
					if (seen.echo  !== want.echo)  diff = {diff, " echo_seq"};
					if (seen.n_crc !== want.n_crc) diff = {diff, " crc_errors"};
					if (seen.n_len !== want.n_len) diff = {diff, " length_errors"};
					if (seen.n_fmt !== want.n_fmt) diff = {diff, " format_errors"};
					if (seen.n_vis !== want.n_vis) diff = {diff, " vision_frames"};
					if (seen.n_imu !== want.n_imu) diff = {diff, " imu_frames"};
					if (diff != "") begin
						failed = 1'b1;
						mismatches++;
						if (mismatches <= 10)
							$display("result mismatch on%s\n  exp %h\n  got %h",
							         diff, want, seen);
					end
				end
				wait_left = $urandom_range(0, gap_max);
			end
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (wait_left > 0) begin
				wait_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	//--------------------------------------------------------------------------
	// byte sender; valid stays up across back-to-back beats
	//--------------------------------------------------------------------------
	task automatic put_byte(input logic [7:0] b);
		int gap;
		gap = $urandom_range(0, gap_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		bytes_sent++;
		parse_byte(b);
	endtask

	// builds one frame; cut > 0 stops after that many bytes
	task automatic send_frame(input logic [7:0] ver, input logic [7:0] kind,
	                          input logic [7:0] len, input bit bad_crc,
	                          input int poison_word, input int cut);
		logic [7:0]  fr[$];
		logic [15:0] c;
		int          n_pay;
		fr = {regs.sync_first, regs.sync_second, ver, kind, 8'($urandom), 8'($urandom), len};
		// an over-limit length is refused at the header, body not sent
		n_pay = (len > 8'(regs.payload_limit)) ? 0 : len;
		repeat (n_pay) fr.push_back(8'($urandom));
		if (poison_word >= 0 && 7 + 4*poison_word + 1 < fr.size()) begin
			fr[7 + 4*poison_word]     |= 8'h7F;
			fr[7 + 4*poison_word + 1] |= 8'h80;
		end
		if (len <= 8'(regs.payload_limit)) begin
			c = 16'hFFFF;
			for (int i = 2; i < fr.size(); i++) c = crc_byte(c, fr[i]);
			if (bad_crc) c ^= 16'(1 << $urandom_range(0, 15));
			fr.push_back(c[15:8]);
			fr.push_back(c[7:0]);
		end
		if (cut > 0 && cut < fr.size()) fr = fr[0:cut-1];
		foreach (fr[i]) put_byte(fr[i]);
	endtask

	// mostly well-formed frames with random content, some faulty, some noise
	task automatic rand_frame();
		int pick;
		logic [7:0] kind, len, ver;
		pick = $urandom_range(0, 99);
		kind = (pick < 45) ? regs.vision_kind : (pick < 85) ? regs.imu_kind : 8'($urandom);
		len  = (kind == regs.vision_kind) ? 8'(regs.vision_length) : 8'(regs.imu_length);
		pick = $urandom_range(0, 99);
		if (pick < 10)
			len = 8'($urandom_range(0, regs.payload_limit));
		else if (pick < 15)
			len = 8'($urandom_range(regs.payload_limit + 1, 255));
		ver = ($urandom_range(0, 19) == 0) ? 8'($urandom) : regs.version_expected;
		send_frame(ver, kind, len, $urandom_range(0, 9) == 0,
		           ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : -1,
		           ($urandom_range(0, 19) == 0) ? $urandom_range(1, 20) : 0);
		repeat ($urandom_range(0, 2)) put_byte(8'($urandom));
	endtask

	//--------------------------------------------------------------------------
	// register writes, only with the block idle
	//--------------------------------------------------------------------------
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_events.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// write enable stays up across consecutive writes; the caller drops it
	task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			REG_SYNC_FIRST:  regs.sync_first       = val;
			REG_SYNC_SECOND: regs.sync_second      = val;
			REG_VERSION:     regs.version_expected = val;
			REG_PAY_LIMIT:   regs.payload_limit    = val[5:0];
			REG_VIS_KIND:    regs.vision_kind      = val;
			REG_IMU_KIND:    regs.imu_kind         = val;
			REG_VIS_LEN:     regs.vision_length    = val[5:0];
			default:         regs.imu_length       = val[5:0];
		endcase
	endtask

	task automatic load_setup(input logic [7:0] s1, input logic [7:0] s2,
	                          input logic [7:0] ver, input logic [5:0] lim,
	                          input logic [7:0] vk, input logic [7:0] ik,
	                          input logic [5:0] vl, input logic [5:0] il);
		settle();
		write_reg(REG_SYNC_FIRST, s1);
		write_reg(REG_SYNC_SECOND, s2);
		write_reg(REG_VERSION, ver);
		write_reg(REG_PAY_LIMIT, 8'(lim));
		write_reg(REG_VIS_KIND, vk);
		write_reg(REG_IMU_KIND, ik);
		write_reg(REG_VIS_LEN, 8'(vl));
		write_reg(REG_IMU_LEN, 8'(il));
		cfg_we <= 1'b0;
	endtask

	//--------------------------------------------------------------------------
	// tests
	//--------------------------------------------------------------------------
	// one of each event at reset setup, plus hunt corner cases
	task automatic test_directed();
		gap_max = 3;
		put_byte(8'h00);
		put_byte(8'hFF);
		put_byte(regs.sync_first);           // repeated first sync keeps the hunt
		send_frame(regs.version_expected, regs.vision_kind, 9, 0, -1, 0);
		send_frame(regs.version_expected, regs.imu_kind, 12, 0, -1, 0);
		send_frame(regs.version_expected, regs.vision_kind, 9, 1, -1, 0);  // crc fault
		send_frame(8'hFF, regs.vision_kind, 9, 0, -1, 0);                  // bad version
		send_frame(regs.version_expected, regs.imu_kind, 17, 0, -1, 0);    // over limit
		send_frame(regs.version_expected, 8'h77, 4, 0, -1, 0);             // wrong type
		send_frame(regs.version_expected, regs.vision_kind, 12, 0, -1, 0); // wrong length
		send_frame(regs.version_expected, regs.vision_kind, 9, 0, 1, 0);   // inf/nan y
		send_frame(regs.version_expected, regs.imu_kind, 12, 0, 2, 0);     // inf/nan z
		send_frame(regs.version_expected, regs.imu_kind, 0, 0, -1, 0);     // empty payload
		// sync pair broken by a foreign byte
		put_byte(regs.sync_first);
		put_byte(8'h13);
		send_frame(regs.version_expected, regs.vision_kind, 9, 0, -1, 0);
	endtask

	// several register setups including the extremes
	task automatic test_setups();
		load_setup(8'h00, 8'hFF, 8'hFF, 6'd55, 8'hFF, 8'h00, 6'd55, 6'd55);
		gap_max = 12;
		repeat (2) rand_frame();
		send_frame(regs.version_expected, regs.vision_kind, 55, 0, -1, 0);
		// equal sync values, zero payload limit, shared type code
		load_setup(8'h7E, 8'h7E, 8'h00, 6'd0, 8'h10, 8'h10, 6'd9, 6'd12);
		gap_max = 0;
		repeat (6) rand_frame();
		send_frame(regs.version_expected, 8'h10, 0, 0, -1, 0);
		load_setup(8'h55, 8'hAA, 8'h03, 6'd20, 8'h07, 8'h09, 6'd20, 6'd12);
		gap_max = 6;
		repeat (8) rand_frame();
	endtask

	// random traffic, randomly mixing busy and bursty stretches
	task automatic test_random_traffic();
		int start_bytes;
		load_setup(8'hAA, 8'h55, 8'h01, 6'd16, 8'h01, 8'h02, 6'd9, 6'd12);
		start_bytes = bytes_sent;
		while (bytes_sent - start_bytes < 200) begin
			gap_max = ($urandom_range(0, 2) == 0) ? 0 : 12;
			repeat (4) rand_frame();
		end
	endtask

	// result side held off while frames keep coming: event queue fills up
	task automatic test_output_hold();
		gap_max = 0;
		hold_request = 1'b1;
		repeat (8) send_frame(regs.version_expected, regs.imu_kind, 12, 0, -1, 0);
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = REG_SYNC_FIRST;
		cfg_data     = 8'h00;
		in_valid     = 1'b0;
		rx_byte      = 8'h00;
		out_stall    = 1'b0;
		mismatches   = 0;
		failed       = 1'b0;
		idle_cycles  = 0;
		gap_max      = 0;
		hold_request = 1'b0;
		bytes_sent   = 0;
		regs = '{8'hAA, 8'h55, 8'h01, 6'd16, 8'h01, 8'h02, 6'd9, 6'd12};
		foreach (store[i]) store[i] = 8'h00;
		t_crc = 0; t_len = 0; t_fmt = 0; t_vis = 0; t_imu = 0;
		rehunt();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_setups();
		test_random_traffic();
		test_output_hold();

		settle();
		if (failed)
			$display("tb_sync_frame_crc16_deframer: FAIL");
		else
			$display("tb_sync_frame_crc16_deframer: PASS");
		$finish;
	end

endmodule
`default_nettype wire
